>>> hw/rtl/dtc_pkg.sv
// dtc_pkg: shared types, constants and the microcode rom of the die temperature block
// used by dtc_useq, dtc_div, dtc_ring and die_temp_conversion_avg; no dependencies
package dtc_pkg;

    // configuration and field widths
    localparam int SAMPLE_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_W      = 16;
    localparam int FAULT_W    = 2;
    localparam int WINDOW_DEF = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_30C  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_110C = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VREF_CAL = 2'd2;

    // register reset values
    localparam logic [SAMPLE_W-1:0] CAL_30C_RST  = 12'd1727;
    localparam logic [SAMPLE_W-1:0] CAL_110C_RST = 12'd1308;
    localparam logic [SAMPLE_W-1:0] VREF_CAL_RST = 12'd1520;

    // fault codes
    localparam logic [FAULT_W-1:0] FAULT_OK        = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_VREF_ZERO = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_CAL_BAD   = 2'd2;

    // arithmetic constants
    localparam logic [SAMPLE_W-1:0] CAL_MV        = 12'd3300;
    localparam logic [SAMPLE_W-1:0] SLOPE_SPAN    = 12'd800;
    localparam logic [SAMPLE_W-1:0] OFFSET_TENTHS = 12'd300;

    // datapath widths
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = SAMPLE_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 40;
    localparam int DIVD_W  = 34;
    localparam int DIVS_W  = 24;
    localparam int DIV_QW  = 16;

    // microcode fields
    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_VREF = 3'd1,
        MUL_C30  = 3'd2,
        MUL_TV   = 3'd3,
        MUL_X800 = 3'd4,
        MUL_DEN  = 3'd5,
        MUL_OFS  = 3'd6
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2,
        ACC_SUB  = 2'd3
    } t_acc_op;

    typedef enum logic [1:0] {
        DIV_MV   = 2'd0,
        DIV_TEMP = 2'd1
    } t_div_src;

    typedef enum logic [1:0] {
        WR_NONE   = 2'd0,
        WR_MV     = 2'd1,
        WR_TENTHS = 2'd2,
        WR_AVG    = 2'd3
    } t_wr_sel;

    typedef enum logic [2:0] {
        JC_NONE    = 3'd0,
        JC_ALWAYS  = 3'd1,
        JC_VS_ZERO = 3'd2,
        JC_CAL_BAD = 3'd3,
        JC_ACC_NEG = 3'd4
    } t_jcond;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    // program addresses
    localparam t_step S_IDLE     = 5'd0;
    localparam t_step S_MV_MUL   = 5'd1;
    localparam t_step S_MV_DIV   = 5'd2;
    localparam t_step S_MV_WAIT  = 5'd3;
    localparam t_step S_MV_WR    = 5'd4;
    localparam t_step S_T_CAL    = 5'd5;
    localparam t_step S_T_TV     = 5'd6;
    localparam t_step S_T_X800   = 5'd7;
    localparam t_step S_T_DEN    = 5'd8;
    localparam t_step S_T_OFS    = 5'd9;
    localparam t_step S_T_DIV    = 5'd10;
    localparam t_step S_T_WAIT   = 5'd11;
    localparam t_step S_T_WR     = 5'd12;
    localparam t_step S_RING_RD  = 5'd13;
    localparam t_step S_RING_WR  = 5'd14;
    localparam t_step S_AVG_WR   = 5'd15;
    localparam t_step S_OUT      = 5'd16;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     den_ld;
        logic     div_start;
        t_div_src div_src;
        logic     wait_div;
        t_wr_sel  wr_sel;
        logic     ring_rd;
        logic     ring_wr;
        logic     wait_in;
        logic     out_load;
        t_jcond   jcond;
        t_step    jtarget;
    } t_ucode;

    // conditions seen by the sequencer
    typedef struct packed {
        logic in_accept;
        logic vs_zero;
        logic cal_bad;
        logic acc_neg;
        logic div_busy;
        logic out_free;
    } t_cond;

    function automatic t_ucode ucode_rom(input t_step s);
        t_ucode w;
        w = '0;
        case (s)
            S_IDLE: begin
                w.wait_in = 1'b1;
            end
            S_MV_MUL: begin
                w.mul_sel = MUL_VREF;
                w.acc_op  = ACC_LOAD;
            end
            S_MV_DIV: begin
                w.div_start = 1'b1;
                w.div_src   = DIV_MV;
                w.jcond     = JC_VS_ZERO;
                w.jtarget   = S_T_CAL;
            end
            S_MV_WAIT: begin
                w.wait_div = 1'b1;
            end
            S_MV_WR: begin
                w.wr_sel = WR_MV;
            end
            S_T_CAL: begin
                w.mul_sel = MUL_C30;
                w.acc_op  = ACC_LOAD;
                w.jcond   = JC_CAL_BAD;
                w.jtarget = S_AVG_WR;
            end
            S_T_TV: begin
                w.mul_sel = MUL_TV;
                w.acc_op  = ACC_SUB;
            end
            S_T_X800: begin
                w.mul_sel = MUL_X800;
                w.acc_op  = ACC_LOAD;
            end
            S_T_DEN: begin
                w.mul_sel = MUL_DEN;
                w.den_ld  = 1'b1;
            end
            S_T_OFS: begin
                w.mul_sel = MUL_OFS;
                w.acc_op  = ACC_ADD;
            end
            S_T_DIV: begin
                w.div_start = 1'b1;
                w.div_src   = DIV_TEMP;
                w.jcond     = JC_ACC_NEG;
                w.jtarget   = S_RING_RD;
            end
            S_T_WAIT: begin
                w.wait_div = 1'b1;
            end
            S_T_WR: begin
                w.wr_sel = WR_TENTHS;
            end
            S_RING_RD: begin
                w.ring_rd = 1'b1;
            end
            S_RING_WR: begin
                w.ring_wr = 1'b1;
            end
            S_AVG_WR: begin
                w.wr_sel = WR_AVG;
            end
            S_OUT: begin
                w.out_load = 1'b1;
                w.jcond    = JC_ALWAYS;
                w.jtarget  = S_IDLE;
            end
            default: begin
                w.jcond   = JC_ALWAYS;
                w.jtarget = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/die_temp_conversion_avg.sv
// die_temp_conversion_avg: each input beat runs the microcode program to a result in the output
// register (a shorter path with a zero reference sample, a negative temperature or bad
// calibration), its divisions one after the other on the shared divider; one item at a time,
// a new beat is taken only once the last result is in the output register, which waits on a stall
// synchronous active-low reset restores the calibration defaults, empties the ring through its
// valid bits at once (no clearing pass) and drops any pending result
// depends on dtc_pkg, dtc_useq, dtc_div, dtc_ring
module die_temp_conversion_avg #(
    parameter int WINDOW = dtc_pkg::WINDOW_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dtc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dtc_pkg::SAMPLE_W-1:0]   i_cfg_data,
    // input sample pair
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [dtc_pkg::SAMPLE_W-1:0]   i_temp_sample,
    input  logic [dtc_pkg::SAMPLE_W-1:0]   i_vref_sample,
    // result
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [dtc_pkg::OUT_W-1:0]      o_supply_mv,
    output logic [dtc_pkg::OUT_W-1:0]      o_sample_tenths,
    output logic [dtc_pkg::OUT_W-1:0]      o_avg_tenths,
    output logic [dtc_pkg::FAULT_W-1:0]    o_fault
);
    import dtc_pkg::*;

    localparam int SUM_W = $clog2(WINDOW * 65535 + 1);

    // mean by reciprocal multiplication, exact for every sum the ring can hold
    localparam int     AVG_LOG_W   = $clog2(WINDOW);
    localparam int     AVG_SH      = SUM_W + AVG_LOG_W;
    localparam int     AVG_RCP_W   = SUM_W + 2;
    localparam int     AVG_PROD_W  = SUM_W + AVG_RCP_W;
    localparam longint AVG_RCP_VAL = ((longint'(1) << AVG_SH) + longint'(WINDOW) - longint'(1))
                                     / longint'(WINDOW);
    localparam logic [AVG_RCP_W-1:0] AVG_RCP = AVG_RCP_W'(AVG_RCP_VAL);

    // calibration registers
    logic [SAMPLE_W-1:0] r_cal30;
    logic [SAMPLE_W-1:0] r_cal110;
    logic [SAMPLE_W-1:0] r_vref_cal;

    // working registers of the current item
    logic [SAMPLE_W-1:0]     r_ts;
    logic [SAMPLE_W-1:0]     r_vs;
    logic [OUT_W-1:0]        r_mv;
    logic [OUT_W-1:0]        r_tenths;
    logic [OUT_W-1:0]        r_avg;
    logic signed [ACC_W-1:0] r_acc;
    logic [DIVS_W-1:0]       r_den;

    // output register
    logic                r_o_valid;
    logic [OUT_W-1:0]    r_o_mv;
    logic [OUT_W-1:0]    r_o_tenths;
    logic [OUT_W-1:0]    r_o_avg;
    logic [FAULT_W-1:0]  r_o_fault;

    t_ucode w_cw;
    t_cond  w_cond;
    logic   w_accept;
    logic   w_out_free;
    logic   w_cal_bad;

    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_prod_acc;

    logic [DIVD_W-1:0]     w_div_dvd;
    logic [DIVS_W-1:0]     w_div_dvs;
    logic                  w_div_busy;
    logic [DIV_QW-1:0]     w_div_q;
    logic                  w_div_sat;
    logic [OUT_W-1:0]      w_div_res;
    logic [SUM_W-1:0]      w_sum;
    logic [AVG_PROD_W-1:0] w_avg_prod;
    logic [OUT_W-1:0]      w_avg;

    // handshakes: new sample only while the sequencer sits in its idle step
    assign o_in_stall  = !w_cw.wait_in;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_o_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    assign w_cal_bad = r_cal30 <= r_cal110;

    assign w_cond.in_accept = w_accept;
    assign w_cond.vs_zero   = (r_vs == '0);
    assign w_cond.cal_bad   = w_cal_bad;
    assign w_cond.acc_neg   = r_acc[ACC_W-1];
    assign w_cond.div_busy  = w_div_busy;
    assign w_cond.out_free  = w_out_free;

    dtc_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (w_cond),
        .o_cw    (w_cw)
    );

    // config writes, low 12 bits kept, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal30    <= CAL_30C_RST;
            r_cal110   <= CAL_110C_RST;
            r_vref_cal <= VREF_CAL_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAL_30C:  r_cal30    <= i_cfg_data;
                CFG_CAL_110C: r_cal110   <= i_cfg_data;
                CFG_VREF_CAL: r_vref_cal <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared multiplier, operands chosen by the control word
    always_comb begin
        case (w_cw.mul_sel)
            MUL_VREF: begin
                w_mul_a = $signed(MUL_A_W'(r_vref_cal));
                w_mul_b = $signed({1'b0, CAL_MV});
            end
            MUL_C30: begin
                w_mul_a = $signed(MUL_A_W'(r_cal30));
                w_mul_b = $signed({1'b0, CAL_MV});
            end
            MUL_TV: begin
                w_mul_a = $signed(MUL_A_W'(r_mv));
                w_mul_b = $signed({1'b0, r_ts});
            end
            MUL_X800: begin
                w_mul_a = r_acc[MUL_A_W-1:0];
                w_mul_b = $signed({1'b0, SLOPE_SPAN});
            end
            MUL_DEN: begin
                w_mul_a = $signed(MUL_A_W'(r_cal30 - r_cal110));
                w_mul_b = $signed({1'b0, CAL_MV});
            end
            MUL_OFS: begin
                w_mul_a = $signed(MUL_A_W'(r_den));
                w_mul_b = $signed({1'b0, OFFSET_TENTHS});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod     = w_mul_a * w_mul_b;
    assign w_prod_acc = w_prod[ACC_W-1:0];

    // divider operand select
    always_comb begin
        case (w_cw.div_src)
            DIV_MV: begin
                w_div_dvd = r_acc[DIVD_W-1:0];
                w_div_dvs = DIVS_W'(r_vs);
            end
            DIV_TEMP: begin
                w_div_dvd = r_acc[DIVD_W-1:0];
                w_div_dvs = r_den;
            end
            default: begin
                w_div_dvd = '0;
                w_div_dvs = '0;
            end
        endcase
    end

    dtc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_cw.div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_busy     (w_div_busy),
        .o_quot     (w_div_q),
        .o_sat      (w_div_sat)
    );

    // saturate anything at or above 65536
    assign w_div_res = w_div_sat ? {OUT_W{1'b1}} : w_div_q;

    dtc_ring #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (w_cw.ring_rd),
        .i_wr    (w_cw.ring_wr),
        .i_data  (r_tenths),
        .o_sum   (w_sum)
    );

    // ring mean, sum times the rounded-up reciprocal of the window
    assign w_avg_prod = AVG_PROD_W'(w_sum) * AVG_PROD_W'(AVG_RCP);
    assign w_avg      = OUT_W'(w_avg_prod >> AVG_SH);

    // datapath registers; mv preset to full scale for a zero reference sample,
    // tenths preset to zero for bad calibration or a negative temperature
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ts     <= i_temp_sample;
            r_vs     <= i_vref_sample;
            r_mv     <= {OUT_W{1'b1}};
            r_tenths <= '0;
        end else begin
            case (w_cw.wr_sel)
                WR_MV:     r_mv     <= w_div_res;
                WR_TENTHS: r_tenths <= w_div_res;
                WR_AVG:    r_avg    <= w_avg;
                default: ;
            endcase
        end

        case (w_cw.acc_op)
            ACC_LOAD: r_acc <= w_prod_acc;
            ACC_ADD:  r_acc <= r_acc + w_prod_acc;
            ACC_SUB:  r_acc <= r_acc - w_prod_acc;
            default: ;
        endcase

        if (w_cw.den_ld) begin
            r_den <= w_prod[DIVS_W-1:0];
        end
    end

    // output register, loaded by the last step once it is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_cw.out_load && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cw.out_load && w_out_free) begin
            r_o_mv     <= r_mv;
            r_o_tenths <= r_tenths;
            r_o_avg    <= r_avg;
            if (w_cal_bad) begin
                r_o_fault <= FAULT_CAL_BAD;
            end else if (r_vs == '0) begin
                r_o_fault <= FAULT_VREF_ZERO;
            end else begin
                r_o_fault <= FAULT_OK;
            end
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_supply_mv     = r_o_mv;
    assign o_sample_tenths = r_o_tenths;
    assign o_avg_tenths    = r_o_avg;
    assign o_fault         = r_o_fault;

endmodule

>>> hw/rtl/dtc_useq.sv
// dtc_useq: step counter and microcode rom with conditional jumps and wait holds
// depends on dtc_pkg (t_ucode, t_cond, ucode_rom)
module dtc_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dtc_pkg::t_cond  i_cond,
    output dtc_pkg::t_ucode o_cw
);
    import dtc_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_ucode w_rom;
    logic   w_taken;
    logic   w_hold;

    assign w_rom = ucode_rom(r_step);

    always_comb begin
        case (w_rom.jcond)
            JC_NONE:    w_taken = 1'b0;
            JC_ALWAYS:  w_taken = 1'b1;
            JC_VS_ZERO: w_taken = i_cond.vs_zero;
            JC_CAL_BAD: w_taken = i_cond.cal_bad;
            JC_ACC_NEG: w_taken = i_cond.acc_neg;
            default:    w_taken = 1'b0;
        endcase
    end

    assign w_hold = (w_rom.wait_in && !i_cond.in_accept)
                 || (w_rom.out_load && !i_cond.out_free)
                 || (w_rom.wait_div && i_cond.div_busy);

    always_comb begin
        if (w_hold) begin
            n_step = r_step;
        end else if (w_taken) begin
            n_step = w_rom.jtarget;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    // a taken jump skips the division it would have started
    always_comb begin
        o_cw = w_rom;
        if (w_taken) begin
            o_cw.div_start = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> hw/rtl/dtc_div.sv
// dtc_div: shared restoring divider, one quotient bit a cycle, with overflow flag
// depends on dtc_pkg (divider widths)
module dtc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dtc_pkg::DIVD_W-1:0] i_dividend,
    input  logic [dtc_pkg::DIVS_W-1:0] i_divisor,
    output logic                       o_busy,
    output logic [dtc_pkg::DIV_QW-1:0] o_quot,
    output logic                       o_sat
);
    import dtc_pkg::*;

    localparam int CNT_W = $clog2(DIV_QW + 1);
    localparam int SAT_W = DIVS_W + DIV_QW;

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVS_W-1:0] r_dvs;
    logic [DIV_QW-1:0] r_qs;
    logic              r_sat;
    logic [DIVS_W:0]   w_rem_sh;
    logic              w_ge;

    // quotient above the 16-bit range: flag it, the low bits are then meaningless
    assign w_rem_sh = {r_rem, r_qs[DIV_QW-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_QW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= DIVS_W'(i_dividend >> DIV_QW);
            r_qs  <= i_dividend[DIV_QW-1:0];
            r_dvs <= i_divisor;
            r_sat <= SAT_W'(i_dividend) >= {i_divisor, {DIV_QW{1'b0}}};
        end else if (r_busy) begin
            r_rem <= w_ge ? DIVS_W'(w_rem_sh - {1'b0, r_dvs}) : w_rem_sh[DIVS_W-1:0];
            r_qs  <= {r_qs[DIV_QW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_qs;
    assign o_sat  = r_sat;

endmodule

>>> hw/rtl/dtc_ring.sv
// dtc_ring: ring of recent temperatures in a memory, with valid bits, index and sum
// depends on dtc_pkg (OUT_W, WINDOW_DEF)
module dtc_ring #(
    parameter int WINDOW = dtc_pkg::WINDOW_DEF,
    parameter int SUM_W  = $clog2(WINDOW * 65535 + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd,
    input  logic                      i_wr,
    input  logic [dtc_pkg::OUT_W-1:0] i_data,
    output logic [SUM_W-1:0]          o_sum
);
    import dtc_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);

    logic [OUT_W-1:0]  r_mem [WINDOW];
    logic [WINDOW-1:0] r_vld;
    logic [IDX_W-1:0]  r_idx;
    logic [SUM_W-1:0]  r_sum;
    logic [OUT_W-1:0]  r_old;
    logic              r_old_vld;
    logic [SUM_W-1:0]  w_old;

    // never written slot counts as zero
    assign w_old = r_old_vld ? SUM_W'(r_old) : '0;

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_old <= r_mem[r_idx];
        end
        if (i_wr) begin
            r_mem[r_idx] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_idx     <= '0;
            r_sum     <= '0;
            r_old_vld <= 1'b0;
        end else begin
            if (i_rd) begin
                r_old_vld <= r_vld[r_idx];
            end
            if (i_wr) begin
                r_vld[r_idx] <= 1'b1;
                r_sum        <= r_sum - w_old + SUM_W'(i_data);
                r_idx        <= (r_idx == IDX_W'(WINDOW - 1)) ? '0 : r_idx + IDX_W'(1);
            end
        end
    end

    assign o_sum = r_sum;

endmodule
